[rtl/csvfs_pkg.sv]
`timescale 1ns / 1ps
// csvfs_pkg: shared types and constants of the CSV field splitter.
// Used by csvfs_ctrl, csvfs_dp and csv_field_splitter; no dependencies.
package csvfs_pkg;

  localparam int unsigned HELD_DEPTH = 16;
  localparam int unsigned HELD_CNT_W = $clog2(HELD_DEPTH + 1);
  localparam int unsigned HELD_IDX_W = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;

  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_LINE  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_HOLD,
    ACT_BYTE,
    ACT_FIELD,
    ACT_LINE
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_CHAR
  } state_e;

  typedef struct packed {
    logic accept;
    logic emit_held;
    logic emit_char;
  } ctrl_cmd_t;

  typedef struct packed {
    logic can_load;
    logic flush_need;
    logic idx_done;
  } dp_status_t;

endpackage

[rtl/csvfs_ctrl.sv]
`timescale 1ns / 1ps
// csvfs_ctrl: sequencer of the CSV field splitter (accept, flush held run, emit byte).
// Depends on csvfs_pkg.
module csvfs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  csvfs_pkg::dp_status_t  status_i,
  output csvfs_pkg::ctrl_cmd_t   cmd_o
);
  import csvfs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.can_load && status_i.flush_need) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status_i.can_load && status_i.idx_done) begin
          state_d = ST_CHAR;
        end
      end
      ST_CHAR: begin
        if (status_i.can_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = status_i.can_load;
        cmd_o.accept = in_valid_i && status_i.can_load;
      end
      ST_FLUSH: begin
        cmd_o.emit_held = status_i.can_load;
      end
      ST_CHAR: begin
        cmd_o.emit_char = status_i.can_load;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

[rtl/csvfs_dp.sv]
`timescale 1ns / 1ps
// csvfs_dp: datapath of the CSV field splitter: quote and field state, held
// whitespace buffer, byte decode and output register. Depends on csvfs_pkg.
module csvfs_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            char_byte_i,
  input  logic                  line_done_i,
  input  csvfs_pkg::ctrl_cmd_t  cmd_i,
  output csvfs_pkg::dp_status_t status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            kind_o,
  output logic [7:0]            out_byte_o,
  output logic                  truncated_o,
  output logic                  last_o
);
  import csvfs_pkg::*;

  logic in_quotes_q, in_quotes_d;
  logic single_q, single_d;
  logic pending_q, pending_d;
  logic content_q;
  logic ovf_q;
  logic [HELD_CNT_W-1:0] cnt_q;
  logic [HELD_IDX_W-1:0] idx_q;
  logic [7:0] held_q [HELD_DEPTH];
  logic [7:0] char_q;

  logic       out_valid_q;
  kind_e      kind_q;
  logic [7:0] byte_q;
  logic       trunc_q;
  logic       last_q;

  logic [7:0] qc;
  logic       is_quote, is_sp, take;
  act_e       act;
  logic       cnt_full;
  logic       load;

  assign qc       = single_q ? CHAR_SQUOTE : CHAR_DQUOTE;
  assign is_quote = (char_byte_i == CHAR_DQUOTE) || (char_byte_i == CHAR_SQUOTE);
  assign is_sp    = (char_byte_i == CHAR_SPACE) ||
                    ((char_byte_i >= CHAR_TAB) && (char_byte_i <= CHAR_CR));
  assign cnt_full = (cnt_q >= HELD_CNT_W'(HELD_DEPTH));

  // Decode of the offered item against the current quote state.
  always_comb begin
    in_quotes_d = in_quotes_q;
    single_d    = single_q;
    pending_d   = 1'b0;
    take        = 1'b0;
    act         = ACT_NONE;
    if (line_done_i) begin
      in_quotes_d = 1'b0;
      single_d    = 1'b0;
      act         = ACT_LINE;
    end else if (pending_q && (char_byte_i == qc)) begin
      take = 1'b1;
    end else begin
      if (pending_q) begin
        in_quotes_d = 1'b0;
      end
      if (pending_q ? 1'b0 : in_quotes_q) begin
        if (char_byte_i == qc) begin
          pending_d = 1'b1;
        end else begin
          take = 1'b1;
        end
      end else if (is_quote && !content_q) begin
        in_quotes_d = 1'b1;
        single_d    = (char_byte_i == CHAR_SQUOTE);
      end else if (char_byte_i == CHAR_COMMA) begin
        act = ACT_FIELD;
      end else begin
        take = 1'b1;
      end
    end
    if (take) begin
      if (!is_sp) begin
        act = ACT_BYTE;
      end else if (content_q) begin
        act = ACT_HOLD;
      end else begin
        act = ACT_NONE;
      end
    end
  end

  assign status_o.can_load   = !out_valid_q || out_ready_i;
  assign status_o.flush_need = (act == ACT_BYTE) && (cnt_q != '0);
  assign status_o.idx_done   = ({1'b0, idx_q} + HELD_CNT_W'(1)) == cnt_q;

  assign load = cmd_i.emit_held || cmd_i.emit_char ||
                (cmd_i.accept && ((act == ACT_LINE) || (act == ACT_FIELD) ||
                                  ((act == ACT_BYTE) && (cnt_q == '0))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quotes_q <= 1'b0;
      single_q    <= 1'b0;
      pending_q   <= 1'b0;
      content_q   <= 1'b0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        in_quotes_q <= in_quotes_d;
        single_q    <= single_d;
        pending_q   <= pending_d;
        idx_q       <= '0;
        case (act)
          ACT_HOLD: begin
            if (cnt_full) begin
              ovf_q <= 1'b1;
            end else begin
              cnt_q <= cnt_q + HELD_CNT_W'(1);
            end
          end
          ACT_BYTE: content_q <= 1'b1;
          ACT_FIELD, ACT_LINE: begin
            content_q <= 1'b0;
            ovf_q     <= 1'b0;
            cnt_q     <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.emit_held) begin
        idx_q <= idx_q + HELD_IDX_W'(1);
      end
      if (cmd_i.emit_char) begin
        cnt_q <= '0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (act == ACT_HOLD) && !cnt_full) begin
      held_q[cnt_q[HELD_IDX_W-1:0]] <= char_byte_i;
    end
    if (cmd_i.accept && (act == ACT_BYTE)) begin
      char_q <= char_byte_i;
    end
    if (load) begin
      if (cmd_i.emit_held) begin
        kind_q  <= KIND_BYTE;
        byte_q  <= held_q[idx_q];
        trunc_q <= 1'b0;
        last_q  <= 1'b0;
      end else if (cmd_i.emit_char) begin
        kind_q  <= KIND_BYTE;
        byte_q  <= char_q;
        trunc_q <= 1'b0;
        last_q  <= 1'b1;
      end else if (act == ACT_BYTE) begin
        kind_q  <= KIND_BYTE;
        byte_q  <= char_byte_i;
        trunc_q <= 1'b0;
        last_q  <= 1'b1;
      end else begin
        kind_q  <= (act == ACT_LINE) ? KIND_LINE : KIND_FIELD;
        byte_q  <= '0;
        trunc_q <= ovf_q;
        last_q  <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign out_byte_o  = byte_q;
  assign truncated_o = trunc_q;
  assign last_o      = last_q;

endmodule

[rtl/csv_field_splitter.sv]
`timescale 1ns / 1ps
// csv_field_splitter: top level of the streaming CSV field splitter.
// Depends on csvfs_pkg, csvfs_ctrl and csvfs_dp.
//
// Takes one line byte (or an end-of-line mark) per transaction and returns
// unquoted, whitespace-trimmed field bytes, field-end and line-end results
// through a registered output. An item is taken when the output register
// is empty or read in that cycle. A content byte that follows held inner
// whitespace is not sent at once: the held run is replayed one entry a
// cycle, while the output register can take it, from the hold buffer
// (16 entries), then the byte follows, and no item is taken meanwhile. The
// input stalls while a result waits unread in the output register. No
// clearing pass after reset.
module csv_field_splitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       line_done_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       truncated_o,
  output logic       last_o
);
  import csvfs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  csvfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  csvfs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_byte_i (char_byte_i),
    .line_done_i (line_done_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .out_byte_o  (out_byte_o),
    .truncated_o (truncated_o),
    .last_o      (last_o)
  );

endmodule
